[hdl/ssms_pkg.sv]
// ----------------------------------------------------------------------------
// ssms_pkg
// Shared types and defaults for the sorted stream merge/sum unit.
// ----------------------------------------------------------------------------
package ssms_pkg;

  localparam int RATE_WIDTH_DEF = 32;
  localparam int TIME_WIDTH_DEF = 32;

  // Request kind carried in the slave-side tuser
  typedef enum logic [1:0] {
    REQ_LEFT      = 2'd0,
    REQ_RIGHT     = 2'd1,
    REQ_LEFT_END  = 2'd2,
    REQ_RIGHT_END = 2'd3
  } req_e;

  // Which side has to supply the next entry
  typedef enum logic [1:0] {
    NEED_LEFT   = 2'd0,
    NEED_RIGHT  = 2'd1,
    NEED_EITHER = 2'd2,
    NEED_NONE   = 2'd3
  } need_e;

  // Per-result status flags, also the master-side tuser layout (LSB first)
  typedef struct packed {
    logic  all_done;
    need_e need_side;
    logic  out_valid;
  } status_t;

endpackage

[hdl/sorted_stream_merge_sum_unit.sv]
// ----------------------------------------------------------------------------
// sorted_stream_merge_sum_unit
// Two-way time-ordered merge with rate summing on equal time stamps.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata (LSB first)            | tuser (LSB first)
//  ----------+-----+------------------------------+------------------------------
//  s_axis    | in  | rate_value, time_mark_in     | req_type
//  m_axis    | out | bps_total, time_mark         | out_valid, need_side, all_done
//
//  One beat accepted per cycle while m_axis keeps up; exactly one result beat
//  per input. Data passes the input register, then the merge step (one time
//  compare and one rate add in the core) feeding the result register.
//  Reset empties both slots and reopens both streams.
//  A stalled m_axis holds its beat; the input register still takes one more
//  beat, then s_axis_tready drops until the result register frees up.
// ----------------------------------------------------------------------------
module sorted_stream_merge_sum_unit #(
  parameter int RATE_WIDTH = ssms_pkg::RATE_WIDTH_DEF,
  parameter int TIME_WIDTH = ssms_pkg::TIME_WIDTH_DEF,
  localparam int S_TDATA_W = ((RATE_WIDTH + TIME_WIDTH + 7) / 8) * 8,
  localparam int M_TDATA_W = ((RATE_WIDTH + 1 + TIME_WIDTH + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // rate_value, time_mark_in, zero pad
  input  logic [1:0]           s_axis_tuser_i,  // req_type
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,  // bps_total, time_mark, zero pad
  output logic [3:0]           m_axis_tuser_o   // out_valid, need_side[1:0], all_done
);

  localparam int M_USED_W = RATE_WIDTH + 1 + TIME_WIDTH;

  // input register
  logic                  in_vld_q, in_vld_d;
  ssms_pkg::req_e        in_kind_q;
  logic [RATE_WIDTH-1:0] in_rate_q;
  logic [TIME_WIDTH-1:0] in_time_q;

  // result register
  logic                  out_vld_q, out_vld_d;
  ssms_pkg::status_t     out_stat_q;
  logic [RATE_WIDTH:0]   out_bps_q;
  logic [TIME_WIDTH-1:0] out_time_q;

  ssms_pkg::status_t     step_stat;
  logic [RATE_WIDTH:0]   step_bps;
  logic [TIME_WIDTH-1:0] step_time;

  logic out_free, step, s_load;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;
  assign s_load          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_load)    in_vld_d = 1'b1;
    else if (step) in_vld_d = 1'b0;

    out_vld_d = out_vld_q;
    if (step)                 out_vld_d = 1'b1;
    else if (m_axis_tready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_load) begin
      in_kind_q <= ssms_pkg::req_e'(s_axis_tuser_i);
      in_rate_q <= s_axis_tdata_i[RATE_WIDTH-1:0];
      in_time_q <= s_axis_tdata_i[RATE_WIDTH +: TIME_WIDTH];
    end
    if (step) begin
      out_stat_q <= step_stat;
      out_bps_q  <= step_bps;
      out_time_q <= step_time;
    end
  end

  ssms_merge_core #(
    .RATE_WIDTH (RATE_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .kind_i   (in_kind_q),
    .rate_i   (in_rate_q),
    .time_i   (in_time_q),
    .status_o (step_stat),
    .bps_o    (step_bps),
    .time_o   (step_time)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_stat_q;
  assign m_axis_tdata_o  = M_TDATA_W'({out_time_q, out_bps_q});

  // M_USED_W documents the packed width; pad bits above it are zero
  if (M_USED_W > M_TDATA_W) begin : g_bad_width
    $error("result tdata too narrow");
  end

endmodule

[hdl/ssms_merge_core.sv]
// ----------------------------------------------------------------------------
// ssms_merge_core
// Two holding slots plus end flags; one merge step per strobe.
// ----------------------------------------------------------------------------
module ssms_merge_core #(
  parameter int RATE_WIDTH = ssms_pkg::RATE_WIDTH_DEF,
  parameter int TIME_WIDTH = ssms_pkg::TIME_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  ssms_pkg::req_e        kind_i,
  input  logic [RATE_WIDTH-1:0] rate_i,
  input  logic [TIME_WIDTH-1:0] time_i,
  output ssms_pkg::status_t     status_o,
  output logic [RATE_WIDTH:0]   bps_o,
  output logic [TIME_WIDTH-1:0] time_o
);

  logic                  l_held_q, l_held_d, r_held_q, r_held_d;
  logic                  l_end_q, l_end_d, r_end_q, r_end_d;
  logic [RATE_WIDTH-1:0] l_rate_q, l_rate_d, r_rate_q, r_rate_d;
  logic [TIME_WIDTH-1:0] l_time_q, l_time_d, r_time_q, r_time_d;

  logic want_l, want_r;

  always_comb begin
    l_held_d = l_held_q;
    r_held_d = r_held_q;
    l_end_d  = l_end_q;
    r_end_d  = r_end_q;
    l_rate_d = l_rate_q;
    r_rate_d = r_rate_q;
    l_time_d = l_time_q;
    r_time_d = r_time_q;
    bps_o    = '0;
    time_o   = '0;
    status_o.out_valid = 1'b0;

    // apply the request; entries for a closed side or a full slot are dropped
    case (kind_i)
      ssms_pkg::REQ_LEFT: begin
        if (!l_end_q && !l_held_q) begin
          l_held_d = 1'b1;
          l_rate_d = rate_i;
          l_time_d = time_i;
        end
      end
      ssms_pkg::REQ_RIGHT: begin
        if (!r_end_q && !r_held_q) begin
          r_held_d = 1'b1;
          r_rate_d = rate_i;
          r_time_d = time_i;
        end
      end
      ssms_pkg::REQ_LEFT_END:  l_end_d = 1'b1;
      ssms_pkg::REQ_RIGHT_END: r_end_d = 1'b1;
      default: ;
    endcase

    // emit from the updated slots
    if (l_held_d && r_held_d) begin
      status_o.out_valid = 1'b1;
      if (l_time_d < r_time_d) begin
        bps_o    = {1'b0, l_rate_d};
        time_o   = l_time_d;
        l_held_d = 1'b0;
      end else if (r_time_d < l_time_d) begin
        bps_o    = {1'b0, r_rate_d};
        time_o   = r_time_d;
        r_held_d = 1'b0;
      end else begin
        bps_o    = {1'b0, l_rate_d} + {1'b0, r_rate_d};
        time_o   = l_time_d;
        l_held_d = 1'b0;
        r_held_d = 1'b0;
      end
    end else if (l_held_d && r_end_d) begin
      status_o.out_valid = 1'b1;
      bps_o    = {1'b0, l_rate_d};
      time_o   = l_time_d;
      l_held_d = 1'b0;
    end else if (r_held_d && l_end_d) begin
      status_o.out_valid = 1'b1;
      bps_o    = {1'b0, r_rate_d};
      time_o   = r_time_d;
      r_held_d = 1'b0;
    end

    want_l = !l_held_d && !l_end_d;
    want_r = !r_held_d && !r_end_d;
    if (want_l && want_r)  status_o.need_side = ssms_pkg::NEED_EITHER;
    else if (want_l)       status_o.need_side = ssms_pkg::NEED_LEFT;
    else if (want_r)       status_o.need_side = ssms_pkg::NEED_RIGHT;
    else                   status_o.need_side = ssms_pkg::NEED_NONE;
    status_o.all_done = l_end_d && r_end_d && !l_held_d && !r_held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_held_q <= 1'b0;
      r_held_q <= 1'b0;
      l_end_q  <= 1'b0;
      r_end_q  <= 1'b0;
      l_rate_q <= '0;
      r_rate_q <= '0;
      l_time_q <= '0;
      r_time_q <= '0;
    end else if (step_i) begin
      l_held_q <= l_held_d;
      r_held_q <= r_held_d;
      l_end_q  <= l_end_d;
      r_end_q  <= r_end_d;
      l_rate_q <= l_rate_d;
      r_rate_q <= r_rate_d;
      l_time_q <= l_time_d;
      r_time_q <= r_time_d;
    end
  end

endmodule

[hdl/ssms_checker.sv]
// ----------------------------------------------------------------------------
// ssms_checker
// Port-level checks for the sorted stream merge/sum unit, bound to the top.
// ----------------------------------------------------------------------------
module ssms_checker #(
  parameter int RATE_WIDTH = ssms_pkg::RATE_WIDTH_DEF,
  parameter int TIME_WIDTH = ssms_pkg::TIME_WIDTH_DEF,
  localparam int M_TDATA_W = ((RATE_WIDTH + 1 + TIME_WIDTH + 7) / 8) * 8
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o,
  input logic [3:0]           m_axis_tuser_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // all done means nobody is asked to supply
  a_done_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[3] |->
      m_axis_tuser_o[2:1] == ssms_pkg::NEED_NONE)
    else $error("all_done with a side still wanted");

  // no merged entry means zero payload
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("payload set on a beat without an entry");

  // no result beat right out of reset
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !m_axis_tvalid_o)
    else $error("result beat right out of reset");

  // input only stalls behind a blocked result beat
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled with the result side free");

endmodule

bind sorted_stream_merge_sum_unit ssms_checker #(
  .RATE_WIDTH (RATE_WIDTH),
  .TIME_WIDTH (TIME_WIDTH)
) u_ssms_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-way sorted merge with equal-time rate sum.
// A stimulus table covers slot fill, full-slot drops, equal-time sums and the
// rate/time extremes. A long run of ordered entries follows the side the unit
// asks for, with some noise mixed in. A closing table ends both streams. Each
// result beat is checked against its typed row or a model of both holding slots.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RW         = ssms_pkg::RATE_WIDTH_DEF;
  localparam int TW         = ssms_pkg::TIME_WIDTH_DEF;
  localparam int S_W        = ((RW + TW + 7) / 8) * 8;
  localparam int M_W        = ((RW + 1 + TW + 7) / 8) * 8;
  localparam int N_ORDERED  = 820;
  localparam int IDLE_LIMIT = 2000;

  // one merged result as the unit reports it
  typedef struct packed {
    logic            out_valid;
    logic [RW:0]     bps;
    logic [TW-1:0]   tm;
    ssms_pkg::need_e need;
    logic            done;
  } merge_t;

  // table row; typed == 1 means exp holds the result to check
  typedef struct packed {
    ssms_pkg::req_e kind;
    logic [RW-1:0]  rate;
    logic [TW-1:0]  tm;
    logic           typed;
    merge_t         exp;
  } stim_row_t;

  typedef struct packed {
    logic          held;
    logic [RW-1:0] rate;
    logic [TW-1:0] tm;
    logic          ended;
  } slot_t;

  localparam merge_t NO_TYPED = '0;

  // streams stay open through this table
  localparam stim_row_t OPEN_ROWS [14] = '{
    '{ssms_pkg::REQ_LEFT,  32'd5,          32'd10,         1'b1,
      '{1'b0, 33'd0, 32'd0, ssms_pkg::NEED_RIGHT, 1'b0}},
    // left slot already full: dropped
    '{ssms_pkg::REQ_LEFT,  32'd7,          32'd3,          1'b1,
      '{1'b0, 33'd0, 32'd0, ssms_pkg::NEED_RIGHT, 1'b0}},
    '{ssms_pkg::REQ_RIGHT, 32'd9,          32'd20,         1'b1,
      '{1'b1, 33'd5, 32'd10, ssms_pkg::NEED_LEFT, 1'b0}},
    '{ssms_pkg::REQ_LEFT,  32'hFFFF_FFFF,  32'd20,         1'b1,
      '{1'b1, 33'h1_0000_0008, 32'd20, ssms_pkg::NEED_EITHER, 1'b0}},
    '{ssms_pkg::REQ_RIGHT, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1,
      '{1'b0, 33'd0, 32'd0, ssms_pkg::NEED_LEFT, 1'b0}},
    // widest sum at the latest time
    '{ssms_pkg::REQ_LEFT,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1,
      '{1'b1, 33'h1_FFFF_FFFE, 32'hFFFF_FFFF, ssms_pkg::NEED_EITHER, 1'b0}},
    '{ssms_pkg::REQ_LEFT,  32'd0,          32'd0,          1'b1,
      '{1'b0, 33'd0, 32'd0, ssms_pkg::NEED_RIGHT, 1'b0}},
    '{ssms_pkg::REQ_RIGHT, 32'd0,          32'd0,          1'b1,
      '{1'b1, 33'd0, 32'd0, ssms_pkg::NEED_EITHER, 1'b0}},
    '{ssms_pkg::REQ_RIGHT, 32'd1,          32'd5,          1'b0, NO_TYPED},
    '{ssms_pkg::REQ_LEFT,  32'd2,          32'd6,          1'b0, NO_TYPED},
    '{ssms_pkg::REQ_RIGHT, 32'd3,          32'd6,          1'b0, NO_TYPED},
    '{ssms_pkg::REQ_RIGHT, 32'hAAAA_AAAA,  32'h5555_5555,  1'b0, NO_TYPED},
    '{ssms_pkg::REQ_LEFT,  32'h5555_5555,  32'hAAAA_AAAA,  1'b0, NO_TYPED},
    '{ssms_pkg::REQ_RIGHT, 32'h0000_1234,  32'hAAAA_AAAA,  1'b0, NO_TYPED}
  };

  // right ends with its slot full, then left ends; everything after is dropped
  localparam stim_row_t CLOSE_ROWS [11] = '{
    '{ssms_pkg::REQ_RIGHT,     32'h11,  32'hFFFF_FFFF, 1'b0, NO_TYPED},
    '{ssms_pkg::REQ_RIGHT_END, 32'h0,   32'h0,         1'b0, NO_TYPED},
    '{ssms_pkg::REQ_RIGHT_END, 32'hFF,  32'hFF,        1'b0, NO_TYPED},
    '{ssms_pkg::REQ_RIGHT,     32'h99,  32'h1,         1'b0, NO_TYPED},
    '{ssms_pkg::REQ_LEFT,      32'h7,   32'h10,        1'b0, NO_TYPED},
    '{ssms_pkg::REQ_LEFT,      32'h22,  32'hFFFF_FFFF, 1'b0, NO_TYPED},
    '{ssms_pkg::REQ_LEFT,      32'h33,  32'h40,        1'b0, NO_TYPED},
    '{ssms_pkg::REQ_LEFT_END,  32'h0,   32'h0,         1'b0, NO_TYPED},
    '{ssms_pkg::REQ_LEFT,      32'h44,  32'h50,        1'b0, NO_TYPED},
    '{ssms_pkg::REQ_RIGHT,     32'h55,  32'h60,        1'b0, NO_TYPED},
    '{ssms_pkg::REQ_LEFT_END,  32'h0,   32'h0,         1'b0, NO_TYPED}
  };

  logic            clk_i    = 1'b0;
  logic            rst_ni   = 1'b0;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [S_W-1:0]  s_tdata  = '0;
  ssms_pkg::req_e  s_tuser  = ssms_pkg::REQ_LEFT;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [M_W-1:0]  m_tdata;
  logic [3:0]      m_tuser;

  slot_t           lft = '0;
  slot_t           rgt = '0;
  ssms_pkg::need_e next_need = ssms_pkg::NEED_EITHER;
  merge_t          merge_q [$];
  int              fail_cnt   = 0;
  int              burst_left = 0;
  int              idle_cyc   = 0;
  int              rx_cyc     = 0;
  int              rx_mode    = 0;

  sorted_stream_merge_sum_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // model of the two holding slots; returns the result beat one input causes
  function automatic merge_t merge_predict(input ssms_pkg::req_e kind,
                                           input logic [RW-1:0] rate,
                                           input logic [TW-1:0] tm);
    merge_t r;
    logic   want_l, want_r;
    r = '0;
    case (kind)
      ssms_pkg::REQ_LEFT: begin
        if (!lft.ended && !lft.held) begin
          lft.held = 1'b1;
          lft.rate = rate;
          lft.tm   = tm;
        end
      end
      ssms_pkg::REQ_RIGHT: begin
        if (!rgt.ended && !rgt.held) begin
          rgt.held = 1'b1;
          rgt.rate = rate;
          rgt.tm   = tm;
        end
      end
      ssms_pkg::REQ_LEFT_END: lft.ended = 1'b1;
      default:                rgt.ended = 1'b1;
    endcase

    if (lft.held && rgt.held) begin
      r.out_valid = 1'b1;
      if (lft.tm < rgt.tm) begin
        r.bps    = {1'b0, lft.rate};
        r.tm     = lft.tm;
        lft.held = 1'b0;
      end else if (rgt.tm < lft.tm) begin
        r.bps    = {1'b0, rgt.rate};
        r.tm     = rgt.tm;
        rgt.held = 1'b0;
      end else begin
        r.bps    = {1'b0, lft.rate} + {1'b0, rgt.rate};
        r.tm     = lft.tm;
        lft.held = 1'b0;
        rgt.held = 1'b0;
      end
    end else if (lft.held && rgt.ended) begin
      r.out_valid = 1'b1;
      r.bps       = {1'b0, lft.rate};
      r.tm        = lft.tm;
      lft.held    = 1'b0;
    end else if (rgt.held && lft.ended) begin
      r.out_valid = 1'b1;
      r.bps       = {1'b0, rgt.rate};
      r.tm        = rgt.tm;
      rgt.held    = 1'b0;
    end

    want_l = !lft.held && !lft.ended;
    want_r = !rgt.held && !rgt.ended;
    if (want_l && want_r)  r.need = ssms_pkg::NEED_EITHER;
    else if (want_l)       r.need = ssms_pkg::NEED_LEFT;
    else if (want_r)       r.need = ssms_pkg::NEED_RIGHT;
    else                   r.need = ssms_pkg::NEED_NONE;
    r.done = lft.ended && rgt.ended && !lft.held && !rgt.held;
    return r;
  endfunction

  // drive one beat in bursts with random gaps; returns at the accepting edge
  task automatic send_beat(input ssms_pkg::req_e kind, input logic [RW-1:0] rate,
                           input logic [TW-1:0] tm, input logic typed,
                           input merge_t typed_res);
    merge_t res;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
    end else begin
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_W'({tm, rate});
    s_tuser  <= kind;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    res       = merge_predict(kind, rate, tm);
    next_need = res.need;
    merge_q.push_back(typed ? typed_res : res);
  endtask

  // ordered entries on the side the unit asks for, with some noise
  task automatic feed_ordered();
    int             ordered;
    logic [TW-1:0]  cursor;
    logic [RW-1:0]  rate;
    ssms_pkg::req_e kind;
    ordered = 0;
    cursor  = $urandom_range(0, 1000);
    while (ordered < N_ORDERED) begin
      if ($urandom_range(0, 99) < 12) begin
        // arbitrary entry, usually against a full slot
        kind = $urandom_range(0, 1) ? ssms_pkg::REQ_RIGHT : ssms_pkg::REQ_LEFT;
        send_beat(kind, $urandom, $urandom, 1'b0, NO_TYPED);
      end else begin
        case (next_need)
          ssms_pkg::NEED_LEFT:  kind = ssms_pkg::REQ_LEFT;
          ssms_pkg::NEED_RIGHT: kind = ssms_pkg::REQ_RIGHT;
          default: kind = $urandom_range(0, 1) ? ssms_pkg::REQ_RIGHT : ssms_pkg::REQ_LEFT;
        endcase
        if ($urandom_range(0, 99) == 0) cursor = $urandom;
        // small steps make equal times on both sides common
        cursor = cursor + $urandom_range(0, 2);
        case ($urandom_range(0, 19))
          0:       rate = '0;
          1:       rate = '1;
          default: rate = $urandom;
        endcase
        send_beat(kind, rate, cursor, 1'b0, NO_TYPED);
        ordered++;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (OPEN_ROWS[i])
      send_beat(OPEN_ROWS[i].kind, OPEN_ROWS[i].rate, OPEN_ROWS[i].tm,
                OPEN_ROWS[i].typed, OPEN_ROWS[i].exp);
    feed_ordered();
    foreach (CLOSE_ROWS[i])
      send_beat(CLOSE_ROWS[i].kind, CLOSE_ROWS[i].rate, CLOSE_ROWS[i].tm,
                CLOSE_ROWS[i].typed, CLOSE_ROWS[i].exp);
    s_tvalid <= 1'b0;
    while (merge_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // result side stalls: full rate, coin flip, one in four, long holds
  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 97 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= (rx_cyc % 4 == 0);
      default: m_tready <= (rx_cyc % 24 >= 18);
    endcase
  end

  always @(posedge clk_i) begin
    merge_t            want;
    ssms_pkg::status_t st;
    if (rst_ni && m_tvalid && m_tready) begin
      st = ssms_pkg::status_t'(m_tuser);
      if (merge_q.size() == 0) begin
        $error("result beat with nothing expected");
        fail_cnt++;
      end else begin
        want = merge_q.pop_front();
        if (st.out_valid !== want.out_valid) begin
          $error("out_valid: expected %0d, got %0d", want.out_valid, st.out_valid);
          fail_cnt++;
        end
        if (m_tdata[RW:0] !== want.bps) begin
          $error("bps_total: expected %0h, got %0h", want.bps, m_tdata[RW:0]);
          fail_cnt++;
        end
        if (m_tdata[RW+TW:RW+1] !== want.tm) begin
          $error("time_mark: expected %0h, got %0h", want.tm, m_tdata[RW+TW:RW+1]);
          fail_cnt++;
        end
        if (st.need_side !== want.need) begin
          $error("need_side: expected %0d, got %0d", want.need, st.need_side);
          fail_cnt++;
        end
        if (st.all_done !== want.done) begin
          $error("all_done: expected %0d, got %0d", want.done, st.all_done);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog: too long without a beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cyc <= 0;
      end else if (idle_cyc >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cyc <= idle_cyc + 1;
      end
    end
  end

endmodule
